// ===== hdl/assert_macros.svh =====
// assertion macros shared by the record table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication outside reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/ukrt_pkg.sv =====
// types and constants of the keyed record table
`timescale 1ns / 1ps
`default_nettype none
package ukrt_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FLD_W = 32;
  localparam int REC_W = 3 * FLD_W;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_LOOKUP = 3'd1;
  localparam logic [2:0] CMD_CHANGE = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_LIST   = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SRCH  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_LIST  = 4'b1000
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [REC_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [FLD_W-1:0] key;
    logic [FLD_W-1:0] account;
    logic [FLD_W-1:0] balance;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/ukrt_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ukrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/ukrt_seq.sv =====
// sequencer: search, shift and list walks over the record ram with one key comparator
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ukrt_seq
  import ukrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        cmd,
  input  wire logic [FLD_W-1:0]  key,
  input  wire logic [FLD_W-1:0]  new_key,
  input  wire logic [FLD_W-1:0]  account,
  input  wire logic [FLD_W-1:0]  balance,
  input  wire logic [REC_W-1:0]  rd_data,
  output logic                   busy,
  output ram_req_t               ram,
  output result_t                res
);

  state_t           state, state_next;
  logic [2:0]       op;
  logic [FLD_W-1:0] tkey, nkey, acct, bal;
  logic             phase, phase_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;
  logic [CNT_W-1:0] count, count_next;

  logic             scanning, issue, hit, scan_end;
  logic [FLD_W-1:0] rd_key, rd_acct, rd_bal, target;

  assign busy     = (state != S_IDLE);
  assign scanning = (state == S_SRCH) || (state == S_SHIFT) || (state == S_LIST);
  assign issue    = scanning && (idx < count);
  assign rd_key   = rd_data[REC_W-1 -: FLD_W];
  assign rd_acct  = rd_data[2*FLD_W-1 -: FLD_W];
  assign rd_bal   = rd_data[FLD_W-1:0];
  assign target   = phase ? nkey : tkey;
  // the one shared comparator
  assign hit      = pend && (rd_key == target);
  assign scan_end = !issue && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op   <= cmd;
      tkey <= key;
      nkey <= new_key;
      acct <= account;
      bal  <= balance;
    end
    phase    <= phase_next;
    pos      <= pos_next;
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    phase_next    = phase;
    pos_next      = pos;
    idx_next      = issue ? idx + CNT_W'(1) : idx;
    pend_next     = issue;
    pend_idx_next = issue ? idx[IDX_W-1:0] : pend_idx;
    ram.we        = 1'b0;
    ram.waddr     = count[IDX_W-1:0];
    ram.wdata     = {tkey, acct, bal};
    ram.raddr     = idx[IDX_W-1:0];
    res           = '0;
    res.status    = ST_OK;
    res.last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (start) begin
          idx_next   = '0;
          pend_next  = 1'b0;
          phase_next = 1'b0;
          case (cmd)
            CMD_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                res.valid  = 1'b1;
                res.status = ST_FULL;
              end else begin
                state_next = S_SRCH;
              end
            end
            CMD_LOOKUP, CMD_CHANGE: begin
              state_next = S_SRCH;
            end
            CMD_DELETE: begin
              if (count == '0) begin
                res.valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                state_next = S_SRCH;
              end
            end
            CMD_LIST: begin
              if (count == '0) begin
                res.valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                state_next = S_LIST;
              end
            end
            default: begin
              // unused codes give no result
            end
          endcase
        end
      end

      S_SRCH: begin
        if (hit) begin
          pend_next = 1'b0;
          case (op)
            CMD_LOOKUP: begin
              state_next  = S_IDLE;
              res.valid   = 1'b1;
              res.key     = rd_key;
              res.account = rd_acct;
              res.balance = rd_bal;
            end
            CMD_CHANGE: begin
              if (!phase) begin
                // record found, now make sure the new key is absent
                pos_next   = pend_idx;
                phase_next = 1'b1;
                idx_next   = '0;
              end else begin
                state_next = S_IDLE;
                res.valid  = 1'b1;
                res.status = ST_DUPLICATE;
              end
            end
            CMD_DELETE: begin
              state_next = S_SHIFT;
              idx_next   = CNT_W'(pend_idx) + CNT_W'(1);
            end
            default: begin
              state_next = S_IDLE;
              res.valid  = 1'b1;
              res.status = ST_DUPLICATE;
            end
          endcase
        end else if (scan_end) begin
          state_next = S_IDLE;
          res.valid  = 1'b1;
          case (op)
            CMD_INSERT: begin
              ram.we     = 1'b1;
              count_next = count + CNT_W'(1);
            end
            CMD_CHANGE: begin
              if (phase) begin
                ram.we    = 1'b1;
                ram.waddr = pos;
                ram.wdata = {nkey, acct, bal};
              end else begin
                res.status = ST_NOT_FOUND;
              end
            end
            default: begin
              res.status = ST_NOT_FOUND;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // each later record moves one place forward
        if (pend) begin
          ram.we    = 1'b1;
          ram.waddr = pend_idx - IDX_W'(1);
          ram.wdata = rd_data;
        end
        if (scan_end) begin
          state_next = S_IDLE;
          count_next = count - CNT_W'(1);
          res.valid  = 1'b1;
        end
      end

      S_LIST: begin
        if (pend) begin
          res.valid   = 1'b1;
          res.key     = rd_key;
          res.account = rd_acct;
          res.balance = rd_bal;
          res.last    = (CNT_W'(pend_idx) == count - CNT_W'(1));
        end
        if (scan_end) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
        pend_next  = 1'b0;
      end
    endcase
  end

  `ASSERT_IMP(a_write_when_walking, ram.we, (state == S_SRCH) || (state == S_SHIFT), "ram write outside search or shift")
  `ASSERT_IMP(a_count_steps_by_one, !$past(rst) && (count != $past(count)), (count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1)), "entry count jumped")
  `ASSERT_IMP(a_count_only_when_busy, !$past(rst) && (count != $past(count)), $past(state) != S_IDLE, "entry count changed while idle")

endmodule
`default_nettype wire

// ===== hdl/unique_key_record_table.sv =====
// top level of the keyed record table: sequencer, record ram and result register
//
//   channel   handshake                  beat
//   -------   -------------------------  ------------------------------------------
//   command   start & !busy              cmd, key, new_key, account, balance
//   result    out_valid (one cycle)      status, out_key, out_account, out_balance,
//                                        last
//
// full, empty and unused codes: busy stays low. the other commands walk the records
// held: change walks them again for the new key, delete shifts the later ones forward.
// the walk speed is set by the single read port of the record ram, one record a cycle
// through one key comparator. each result appears in the cycle after the work that
// makes it and is shown for one cycle only; the receiver cannot stall.
// rst clears the record count; the record ram needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module unique_key_record_table
  import ukrt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [2:0]              cmd,
  input  wire logic [FLD_W-1:0]        key,
  input  wire logic [FLD_W-1:0]        new_key,
  input  wire logic [FLD_W-1:0]        account,
  input  wire logic signed [FLD_W-1:0] balance,
  output logic                         out_valid,
  output logic [2:0]                   status,
  output logic [FLD_W-1:0]             out_key,
  output logic [FLD_W-1:0]             out_account,
  output logic signed [FLD_W-1:0]      out_balance,
  output logic                         last
);

  ram_req_t         ram;
  result_t          res;
  logic [REC_W-1:0] rd_data;

  ukrt_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .key     (key),
    .new_key (new_key),
    .account (account),
    .balance ($unsigned(balance)),
    .rd_data (rd_data),
    .busy    (busy),
    .ram     (ram),
    .res     (res)
  );

  ukrt_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    status      <= res.status;
    out_key     <= res.key;
    out_account <= res.account;
    out_balance <= $signed(res.balance);
    last        <= res.last;
  end

  `ASSERT_IMP(a_result_follows_command, out_valid && !$past(rst), $past(busy) || $past(start), "result beat without a command")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the keyed record table
`timescale 1ns / 1ps
module testbench;
  import ukrt_pkg::*;

  localparam int POOL_SIZE = 36;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic [2:0]              cmd;
    logic [FLD_W-1:0]        key;
    logic [FLD_W-1:0]        new_key;
    logic [FLD_W-1:0]        account;
    logic signed [FLD_W-1:0] balance;
    int unsigned             gap;
  } table_cmd_t;

  typedef struct {
    status_t                 status;
    logic [FLD_W-1:0]        key;
    logic [FLD_W-1:0]        account;
    logic signed [FLD_W-1:0] balance;
    logic                    fin;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] cmd = CMD_INSERT;
  logic [FLD_W-1:0] key = '0;
  logic [FLD_W-1:0] new_key = '0;
  logic [FLD_W-1:0] account = '0;
  logic signed [FLD_W-1:0] balance = '0;
  logic busy;
  logic out_valid;
  logic [2:0] status;
  logic [FLD_W-1:0] out_key;
  logic [FLD_W-1:0] out_account;
  logic signed [FLD_W-1:0] out_balance;
  logic last;

  // predicted table contents, valid below rec_count only
  logic [FLD_W-1:0] rec_key [DEPTH];
  logic [FLD_W-1:0] rec_account [DEPTH];
  logic signed [FLD_W-1:0] rec_balance [DEPTH];
  int rec_count = 0;

  table_reply_t replies_due[$];
  table_cmd_t pending_cmds[$];
  table_cmd_t next_cmd;
  table_reply_t due_reply;

  logic [FLD_W-1:0] key_pool [POOL_SIZE];
  int sweep_order [POOL_SIZE];
  bit burst_mode = 1'b0;
  int items_made = 0;
  int mismatches = 0;
  bit cmd_taken = 1'b0;
  int unsigned idle_left = 0;

  unique_key_record_table dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .key(key),
    .new_key(new_key),
    .account(account),
    .balance(balance),
    .out_valid(out_valid),
    .status(status),
    .out_key(out_key),
    .out_account(out_account),
    .out_balance(out_balance),
    .last(last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_item(input logic [2:0] c, input logic [FLD_W-1:0] k, nk, acct,
                          input logic signed [FLD_W-1:0] bal);
    table_cmd_t item;
    item.cmd = c;
    item.key = k;
    item.new_key = nk;
    item.account = acct;
    item.balance = bal;
    item.gap = pick_gap();
    pending_cmds.push_back(item);
    if (c <= CMD_LIST) items_made++;
  endtask

  function automatic logic [FLD_W-1:0] pool_key();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // mostly keys that may be held, now and then one that almost surely is not
  function automatic logic [FLD_W-1:0] probe_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return pool_key();
  endfunction

  task automatic add_random_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) add_item(CMD_INSERT, pool_key(), $urandom, $urandom, $urandom);
    else if (r < 45) add_item(CMD_LOOKUP, probe_key(), $urandom, $urandom, $urandom);
    else if (r < 65) add_item(CMD_CHANGE, probe_key(), pool_key(), $urandom, $urandom);
    else if (r < 82) add_item(CMD_DELETE, probe_key(), $urandom, $urandom, $urandom);
    else if (r < 95) add_item(CMD_LIST, $urandom, $urandom, $urandom, $urandom);
    // codes above list are ignored by the block
    else add_item(CMD_LIST + 3'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                  $urandom);
  endtask

  task automatic shuffle_sweep();
    int j;
    int t;
    for (int i = 0; i < POOL_SIZE; i++) sweep_order[i] = i;
    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = sweep_order[i];
      sweep_order[i] = sweep_order[j];
      sweep_order[j] = t;
    end
  endtask

  function automatic int find_record(input logic [FLD_W-1:0] k);
    for (int i = 0; i < rec_count; i++)
      if (rec_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void queue_reply(input status_t st, input logic [FLD_W-1:0] k, acct,
                                      input logic signed [FLD_W-1:0] bal, input logic fin);
    table_reply_t r;
    r.status = st;
    r.key = k;
    r.account = acct;
    r.balance = bal;
    r.fin = fin;
    replies_due.push_back(r);
  endfunction

  task automatic apply_to_table(input logic [2:0] c, input logic [FLD_W-1:0] k, nk, acct,
                                input logic signed [FLD_W-1:0] bal);
    int slot;
    case (c)
      CMD_INSERT: begin
        // full is reported ahead of duplicate
        if (rec_count >= DEPTH) queue_reply(ST_FULL, '0, '0, '0, 1'b1);
        else if (find_record(k) >= 0) queue_reply(ST_DUPLICATE, '0, '0, '0, 1'b1);
        else begin
          rec_key[rec_count] = k;
          rec_account[rec_count] = acct;
          rec_balance[rec_count] = bal;
          rec_count++;
          queue_reply(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      CMD_LOOKUP: begin
        slot = find_record(k);
        if (slot >= 0)
          queue_reply(ST_OK, rec_key[slot], rec_account[slot], rec_balance[slot], 1'b1);
        else queue_reply(ST_NOT_FOUND, '0, '0, '0, 1'b1);
      end
      CMD_CHANGE: begin
        slot = find_record(k);
        // a new key equal to the old one counts as a duplicate
        if (slot < 0) queue_reply(ST_NOT_FOUND, '0, '0, '0, 1'b1);
        else if (find_record(nk) >= 0) queue_reply(ST_DUPLICATE, '0, '0, '0, 1'b1);
        else begin
          rec_key[slot] = nk;
          rec_account[slot] = acct;
          rec_balance[slot] = bal;
          queue_reply(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        slot = find_record(k);
        if (rec_count == 0) queue_reply(ST_EMPTY, '0, '0, '0, 1'b1);
        else if (slot < 0) queue_reply(ST_NOT_FOUND, '0, '0, '0, 1'b1);
        else begin
          for (int i = slot; i + 1 < rec_count; i++) begin
            rec_key[i] = rec_key[i + 1];
            rec_account[i] = rec_account[i + 1];
            rec_balance[i] = rec_balance[i + 1];
          end
          rec_count--;
          queue_reply(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        if (rec_count == 0) queue_reply(ST_EMPTY, '0, '0, '0, 1'b1);
        else
          for (int i = 0; i < rec_count; i++)
            queue_reply(ST_OK, rec_key[i], rec_account[i], rec_balance[i],
                        i == rec_count - 1);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [FLD_W-1:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: holds start until the beat is taken, then idles for the item's gap
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (idle_left != 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        start <= 1'b1;
        cmd <= next_cmd.cmd;
        key <= next_cmd.key;
        new_key <= next_cmd.new_key;
        account <= next_cmd.account;
        balance <= next_cmd.balance;
        idle_left = next_cmd.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks results, then predicts for a beat taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken = 1'b0;
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          $display("%0t: expected no result, got status %0d key %h account %h balance %h last %b",
                   $time, status, out_key, out_account, out_balance, last);
          mismatches++;
        end else begin
          due_reply = replies_due.pop_front();
          check_field("status", 32'(due_reply.status), 32'(status));
          check_field("out_key", due_reply.key, out_key);
          check_field("out_account", due_reply.account, out_account);
          check_field("out_balance", due_reply.balance, out_balance);
          check_field("last", 32'(due_reply.fin), 32'(last));
        end
      end
      cmd_taken = start && !busy;
      if (cmd_taken) apply_to_table(cmd, key, new_key, account, balance);
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // corner cases on an empty table
    add_item(CMD_LIST, '0, '0, '0, '0);
    add_item(CMD_DELETE, 32'h1, '0, '0, '0);
    add_item(CMD_LOOKUP, 32'h1, '0, '0, '0);
    add_item(CMD_CHANGE, 32'h1, 32'h2, '0, '0);
    // extremes of key, account and balance
    add_item(CMD_INSERT, '0, '1, '0, 32'sh8000_0000);
    add_item(CMD_INSERT, 32'hffff_ffff, '0, 32'hffff_ffff, 32'sh7fff_ffff);
    add_item(CMD_INSERT, '0, '0, 32'h1234_5678, 32'sh1);
    add_item(CMD_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, -32'sd1);
    add_item(CMD_LOOKUP, '0, '1, '1, '1);
    add_item(CMD_LOOKUP, 32'hffff_ffff, '0, '0, '0);
    add_item(CMD_CHANGE, '0, '0, 32'h1, 32'sh1);
    add_item(CMD_CHANGE, '0, 32'hffff_ffff, 32'h1, 32'sh1);
    add_item(CMD_CHANGE, '0, 32'haaaa_aaaa, 32'h5555_5555, '0);
    add_item(CMD_LIST, '1, '1, '1, '1);
    add_item(CMD_DELETE, 32'h1234_5678, '0, '0, '0);
    // middle record goes, later ones move up
    add_item(CMD_DELETE, 32'hffff_ffff, '0, '0, '0);
    add_item(CMD_LIST + 3'd1, '1, '1, '1, '1);
    add_item(CMD_LIST + 3'd2, '0, '0, '0, '0);
    add_item(CMD_LIST + 3'd3, '1, '0, '1, '0);
    add_item(CMD_LOOKUP, 32'h5555_5555, '0, '0, '0);
    add_item(CMD_LIST, '0, '0, '0, '0);
    add_item(CMD_DELETE, 32'haaaa_aaaa, '0, '0, '0);
    add_item(CMD_DELETE, 32'h5555_5555, '0, '0, '0);
    add_item(CMD_DELETE, 32'h5555_5555, '0, '0, '0);
    add_item(CMD_LIST, '0, '0, '0, '0);

    // phases: fill past full, mix, drain towards empty, mix
    items_made = 0;
    for (int phase = 0; items_made < RANDOM_ITEMS; phase++) begin
      burst_mode = ($urandom_range(0, 9) < 3);
      shuffle_sweep();
      case (phase % 4)
        0: begin
          for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 4) == 0) add_random_cmd();
            add_item(CMD_INSERT, key_pool[sweep_order[i]], $urandom, $urandom, $urandom);
          end
        end
        2: begin
          for (int i = 0; i < POOL_SIZE; i++) begin
            if ($urandom_range(0, 4) == 0) add_random_cmd();
            add_item(CMD_DELETE, key_pool[sweep_order[i]], $urandom, $urandom, $urandom);
          end
        end
        default: begin
          repeat ($urandom_range(30, 60)) add_random_cmd();
        end
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (replies_due.size() != 0) @(negedge clk);
    // catch any stray result after the last one due
    repeat (100) @(negedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
